### sv/fbf_pkg.sv
// ---------------------------------------------------------------------------
// Frame fill engine package
// Shared types, command codes, register indexes and the color cut helper.
// ---------------------------------------------------------------------------
package fbf_pkg;

  // Command codes carried on the opcode field.
  localparam logic [2:0] OP_PIXEL = 3'd0;
  localparam logic [2:0] OP_HLINE = 3'd1;
  localparam logic [2:0] OP_RECT  = 3'd2;
  localparam logic [2:0] OP_FILL  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PIXEL_BYTES   = 2'd2;

  // Working address width. Every address a command can form stays below
  // 2^21, and the largest store (2048 x 2048 pixels) needs 23 bits to hold
  // its depth for the range compare.
  localparam int ADDR_W  = 23;
  // Pixel count of one run: the whole frame is at most 511 * 511 pixels.
  localparam int CNT_W   = 18;
  localparam int PIXEL_W = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_RUN,
    S_READ,
    S_DONE
  } state_t;

  // Keeps the low pixel_bytes bytes of a color. Zero acts as one byte and
  // anything above four acts as four.
  function automatic logic [PIXEL_W-1:0] cut_color(input logic [PIXEL_W-1:0] c,
                                                   input logic [2:0] pb);
    logic [PIXEL_W-1:0] mask;
    case (pb)
      3'd0, 3'd1: mask = 32'h0000_00FF;
      3'd2:       mask = 32'h0000_FFFF;
      3'd3:       mask = 32'h00FF_FFFF;
      default:    mask = 32'hFFFF_FFFF;
    endcase
    return c & mask;
  endfunction

endpackage

### sv/fbf_store.sv
// ---------------------------------------------------------------------------
// Frame store
// Single-clock pixel memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module fbf_store import fbf_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [PIXEL_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [PIXEL_W-1:0] rdata
);

  logic [PIXEL_W-1:0] mem [DEPTH];

  // Write when enabled; the read data is registered every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/framebuffer_fill_engine.sv
// ---------------------------------------------------------------------------
// Frame fill engine
// Draws pixels, runs, clipped rectangles and whole-frame fills into a linear
// pixel store, and reads single pixels back.
// ---------------------------------------------------------------------------
//  Channel   | Signals                                           | Transfer
//  ----------+---------------------------------------------------+-------------------
//  command   | start, busy, opcode, pos_x, pos_y, span_len,      | start && !busy
//            | span_rows, color                                  |
//  result    | done, read_value, status                          | done (one cycle)
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data         | cfg_valid && cfg_ready
//
// After the transfer, a pixel write goes through S_SETUP and S_RUN to S_DONE,
// a read through S_SETUP and S_READ, and a rejected rectangle or an unused
// opcode from S_SETUP straight to S_DONE. A run or fill writes one pixel per
// cycle in S_RUN, with one more S_RUN step at each row end: the single store
// write port sets that pace. busy stays high through the done cycle, so the
// next command is taken in the cycle after done at the earliest.
// Reset (rst, synchronous) returns the control to idle and the registers to
// 256 x 256 at 2 bytes per pixel; the store itself is not cleared.
// The result cycle cannot be stalled; busy holds off new commands meanwhile.
// ---------------------------------------------------------------------------
module framebuffer_fill_engine import fbf_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic         clk,
  input  logic         rst,
  // Command channel.
  input  logic         start,
  output logic         busy,
  input  logic [2:0]   opcode,
  input  logic [10:0]  pos_x,
  input  logic [10:0]  pos_y,
  input  logic [10:0]  span_len,
  input  logic [10:0]  span_rows,
  input  logic [31:0]  color,
  // Result channel.
  output logic         done,
  output logic [31:0]  read_value,
  output logic         status,
  // Configuration channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [8:0]   cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(DEPTH);

  state_t state, state_next;

  // Configuration registers.
  logic [8:0] screen_width;
  logic [8:0] screen_height;
  logic [2:0] pixel_bytes;

  // Latched command.
  logic [2:0]         op;
  logic [10:0]        x;
  logic [10:0]        y;
  logic [10:0]        len;
  logic [10:0]        rows;
  logic [PIXEL_W-1:0] pix;

  // Run walker.
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] row_addr;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  run_len;
  logic [10:0]       rows_left;
  logic              reject;
  logic              rd_ok;

  // Setup datapath.
  logic               whole;
  logic [10:0]        mul_a;
  logic [19:0]        prod;
  logic [ADDR_W-1:0]  base;
  logic [11:0]        x_end;
  logic [11:0]        y_end;
  logic [10:0]        len_eff;
  logic [10:0]        rows_eff;
  logic               reject_c;
  logic [CNT_W-1:0]   cnt_init;
  logic [10:0]        rows_init;

  // Store ports.
  logic               we;
  logic               row_end;
  logic               last_row;
  logic [PIXEL_W-1:0] rdata;

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 9'd256;
      screen_height <= 9'd256;
      pixel_bytes   <= 3'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        REG_PIXEL_BYTES:   pixel_bytes   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Start address or frame size: one shared multiplier with the row stride.
  // Whole-frame commands always start at address zero.
  assign whole = (op == OP_FILL) || (op == OP_CLEAR);
  assign mul_a = whole ? {2'b00, screen_height} : y;
  assign prod  = {9'd0, mul_a} * {11'd0, screen_width};
  assign base  = whole ? '0 : ADDR_W'(prod) + ADDR_W'(x);

  // Rectangle rejection and clipping to the screen edge.
  assign reject_c = (op == OP_RECT) &&
                    ((x > {2'b00, screen_width}) || (y > {2'b00, screen_height}));
  assign x_end    = {1'b0, x} + {1'b0, len};
  assign y_end    = {1'b0, y} + {1'b0, rows};
  always_comb begin
    len_eff  = len;
    rows_eff = rows;
    if (x_end >= {3'b000, screen_width}) begin
      len_eff = 11'({2'b00, screen_width} - x);
    end
    if (y_end >= {3'b000, screen_height}) begin
      rows_eff = 11'({2'b00, screen_height} - y);
    end
  end

  // Pixel count of the first row and the number of rows, per command.
  always_comb begin
    rows_init = 11'd1;
    case (op)
      OP_PIXEL: cnt_init = CNT_W'(1);
      OP_HLINE: cnt_init = CNT_W'(len);
      OP_RECT: begin
        rows_init = rows_eff;
        cnt_init  = (rows_eff == 11'd0) ? '0 : CNT_W'(len_eff);
      end
      OP_FILL, OP_CLEAR: cnt_init = prod[CNT_W-1:0];
      default: cnt_init = '0;
    endcase
  end

  assign row_end  = (cnt == '0);
  assign last_row = (rows_left <= 11'd1);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_SETUP;
      end
      S_SETUP: begin
        if (op == OP_READ) begin
          state_next = S_READ;
        end else if (reject_c || op > OP_READ) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (row_end && last_row) state_next = S_DONE;
      end
      S_READ:  state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Outputs of the control.
  always_comb begin
    busy = (state != S_IDLE);
    done = (state == S_DONE);
    we   = (state == S_RUN) && !row_end && (cur_addr < DEPTH_A);
  end

  // Command latch and run walker.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op   <= opcode;
      x    <= pos_x;
      y    <= pos_y;
      len  <= span_len;
      rows <= span_rows;
      pix  <= (opcode == OP_CLEAR) ? '0 : cut_color(color, pixel_bytes);
    end
    case (state)
      S_SETUP: begin
        cur_addr  <= base;
        row_addr  <= base;
        cnt       <= cnt_init;
        run_len   <= cnt_init;
        rows_left <= rows_init;
        reject    <= reject_c;
        rd_ok     <= (op == OP_READ) && (base < DEPTH_A);
      end
      S_RUN: begin
        if (!row_end) begin
          cur_addr <= cur_addr + ADDR_W'(1);
          cnt      <= cnt - CNT_W'(1);
        end else if (!last_row) begin
          // Next row of a rectangle starts one stride further on.
          rows_left <= rows_left - 11'd1;
          row_addr  <= row_addr + ADDR_W'(screen_width);
          cur_addr  <= row_addr + ADDR_W'(screen_width);
          cnt       <= run_len;
        end
      end
      default: ;
    endcase
  end

  fbf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (cur_addr[AW-1:0]),
    .wdata (pix),
    .raddr (cur_addr[AW-1:0]),
    .rdata (rdata)
  );

  // Result ports, valid in the done cycle.
  assign read_value = (done && rd_ok) ? cut_color(rdata, pixel_bytes) : '0;
  assign status     = done && reject;

endmodule
